@@ hdl/bcfe_pkg.sv @@
// Shared types and codes for the bus fetch-execute machine.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package bcfe_pkg;

  // Command codes carried by an input item
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_EXEC    = 3'd1;
  localparam logic [2:0] CMD_RDMEM   = 3'd2;
  localparam logic [2:0] CMD_RDIO    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  // Instruction opcodes
  localparam logic [4:0] OPC_WM  = 5'h01;
  localparam logic [4:0] OPC_RM  = 5'h02;
  localparam logic [4:0] OPC_BR  = 5'h03;
  localparam logic [4:0] OPC_RIO = 5'h04;
  localparam logic [4:0] OPC_WIO = 5'h05;
  localparam logic [4:0] OPC_WB  = 5'h06;
  localparam logic [4:0] OPC_WIB = 5'h07;
  localparam logic [4:0] OPC_EOP = 5'h1F;
  localparam logic [4:0] OPC_NONE = 5'h00;

  // Halt status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_EOP  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic [10:0] program_counter;
    logic [4:0]  opcode;
    logic [7:0]  memory_buffer;
    logic [7:0]  io_buffer_reg;
    logic [10:0] bus_addr;
    logic [7:0]  bus_data;
    logic [4:0]  bus_control;
  } res_t;

endpackage

@@ hdl/bcfe_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; instanced for main memory and the I/O buffer.
`timescale 1ns / 1ps

module bcfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, read the old contents every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/bus_cpu_fetch_execute_top.sv @@
// Top level of the bus fetch-execute machine: sequencer, architectural registers
// and output register. Depends on bcfe_pkg and bcfe_ram.
`timescale 1ns / 1ps

// A small machine with 16-bit big-endian instructions held in a byte-wide main
// memory and a byte-wide I/O buffer, both single-port synchronous RAMs. Each
// input item is one command and gives exactly one result item. An execute
// command passes through accept and two instruction-byte reads on the main memory
// port (S_IDLE, S_FETCH1, S_FETCH2), then S_RDMEM or S_RDIO when the instruction
// reads memory or I/O; load, restart, unused codes and execute while halted
// finish on acceptance, and read memory and read io go through S_RDMEM or S_RDIO.
// The single port of main memory sets this sequence. After reset the I/O buffer
// is cleared, one entry a cycle, and no item is accepted until every entry is
// cleared. A waiting result sits in an output register, so the next item is
// accepted while it waits. Main memory holds undefined bytes until loaded.
module bus_cpu_fetch_execute_top #(
  parameter int MEM_DEPTH = 2048,
  parameter int IO_DEPTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [10:0] address,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  read_data,
  output logic [10:0] program_counter,
  output logic [4:0]  opcode,
  output logic [7:0]  memory_buffer,
  output logic [7:0]  io_buffer_reg,
  output logic [10:0] bus_addr,
  output logic [7:0]  bus_data,
  output logic [4:0]  bus_control
);

  import bcfe_pkg::*;

  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int IO_AW  = $clog2(IO_DEPTH);
  // Reciprocals for address reduction: 11-bit address times 2^22/depth
  localparam logic [22:0] MEM_RECIP = 23'((1 << 22) / MEM_DEPTH);
  localparam logic [22:0] IO_RECIP  = 23'((1 << 22) / IO_DEPTH);
  localparam logic [11:0] MEM_D12   = 12'(MEM_DEPTH);
  localparam logic [11:0] IO_D12    = 12'(IO_DEPTH);
  localparam logic [IO_AW-1:0] IO_LAST = IO_AW'(IO_DEPTH - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH1 = 3'd1;
  localparam logic [2:0] S_FETCH2 = 3'd2;
  localparam logic [2:0] S_RDMEM  = 3'd3;
  localparam logic [2:0] S_RDIO   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Reduce an address modulo the main memory depth
  function automatic logic [MEM_AW-1:0] mem_index(input logic [10:0] a);
    logic [33:0] prod;
    logic [10:0] q;
    logic [22:0] qd;
    logic [11:0] r;
    prod = {23'd0, a} * {11'd0, MEM_RECIP};
    q    = prod[32:22];
    qd   = {12'd0, q} * {11'd0, MEM_D12};
    r    = {1'b0, a} - qd[11:0];
    if (r >= MEM_D12) begin
      r = r - MEM_D12;
    end
    return r[MEM_AW-1:0];
  endfunction

  // Reduce an address modulo the I/O buffer depth
  function automatic logic [IO_AW-1:0] io_index(input logic [10:0] a);
    logic [33:0] prod;
    logic [10:0] q;
    logic [22:0] qd;
    logic [11:0] r;
    prod = {23'd0, a} * {11'd0, IO_RECIP};
    q    = prod[32:22];
    qd   = {12'd0, q} * {11'd0, IO_D12};
    r    = {1'b0, a} - qd[11:0];
    if (r >= IO_D12) begin
      r = r - IO_D12;
    end
    return r[IO_AW-1:0];
  endfunction

  // Sequencer and architectural registers
  logic [2:0]  state, state_next;
  logic [2:0]  cmd, cmd_next;
  logic [7:0]  ir_hi, ir_hi_next;
  logic [10:0] pc, pc_next;
  logic [7:0]  mbr, mbr_next;
  logic [7:0]  iobr, iobr_next;
  logic [1:0]  halt, halt_next;
  logic [10:0] abus, abus_next;
  logic [7:0]  dbus, dbus_next;
  logic [4:0]  cbus, cbus_next;
  logic [7:0]  rd_res, rd_res_next;
  logic [4:0]  op_res, op_res_next;
  logic        clearing;
  logic [IO_AW-1:0] clr_idx;
  res_t        res_q, res_next;
  logic        out_valid_next;

  // Memory ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              io_we;
  logic [IO_AW-1:0]  io_addr;
  logic [7:0]        io_wdata, io_rdata;

  logic        finish;
  logic        out_free;
  logic [4:0]  dec_op;
  logic [10:0] operand;

  bcfe_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_main_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bcfe_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io_ram (
    .clk   (clk),
    .we    (io_we),
    .addr  (io_addr),
    .wdata (io_wdata),
    .rdata (io_rdata)
  );

  assign in_ready = (state == S_IDLE) && !clearing;
  assign out_free = !out_valid || out_ready;
  assign dec_op   = ir_hi[7:3];
  assign operand  = {ir_hi[2:0], mem_rdata};

  // Next-state logic of the sequencer
  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    ir_hi_next  = ir_hi;
    pc_next     = pc;
    mbr_next    = mbr;
    iobr_next   = iobr;
    halt_next   = halt;
    abus_next   = abus;
    dbus_next   = dbus;
    cbus_next   = cbus;
    rd_res_next = rd_res;
    op_res_next = op_res;
    mem_we      = 1'b0;
    mem_addr    = mem_index(pc);
    mem_wdata   = mbr;
    io_we       = clearing;
    io_addr     = clearing ? clr_idx : io_index(address);
    io_wdata    = clearing ? 8'd0 : iobr;
    finish      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_next    = command;
          rd_res_next = 8'd0;
          op_res_next = OPC_NONE;
          unique case (command)
            CMD_LOAD: begin
              mem_addr  = mem_index(address);
              mem_we    = 1'b1;
              mem_wdata = data;
              finish    = 1'b1;
            end
            CMD_EXEC: begin
              if (halt != ST_RUN) begin
                finish = 1'b1;
              end else begin
                mem_addr   = mem_index(pc);
                state_next = S_FETCH1;
              end
            end
            CMD_RDMEM: begin
              mem_addr   = mem_index(address);
              state_next = S_RDMEM;
            end
            CMD_RDIO: begin
              io_addr    = io_index(address);
              state_next = S_RDIO;
            end
            CMD_RESTART: begin
              pc_next   = 11'd0;
              halt_next = ST_RUN;
              finish    = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_FETCH1: begin
        // Take the high byte, read the low byte
        ir_hi_next = mem_rdata;
        abus_next  = pc;
        dbus_next  = mem_rdata;
        pc_next    = pc + 11'd1;
        mem_addr   = mem_index(pc + 11'd1);
        state_next = S_FETCH2;
      end
      S_FETCH2: begin
        // Take the low byte and execute
        abus_next   = pc;
        dbus_next   = mem_rdata;
        pc_next     = pc + 11'd1;
        op_res_next = dec_op;
        finish      = 1'b1;
        unique case (dec_op)
          OPC_WM: begin
            cbus_next = dec_op;
            abus_next = operand;
            dbus_next = mbr;
            mem_addr  = mem_index(operand);
            mem_we    = 1'b1;
            mem_wdata = mbr;
          end
          OPC_RM: begin
            cbus_next  = dec_op;
            abus_next  = operand;
            mem_addr   = mem_index(operand);
            finish     = 1'b0;
            state_next = S_RDMEM;
          end
          OPC_BR: begin
            pc_next = operand;
          end
          OPC_RIO: begin
            cbus_next  = dec_op;
            abus_next  = operand;
            io_addr    = io_index(operand);
            finish     = 1'b0;
            state_next = S_RDIO;
          end
          OPC_WIO: begin
            cbus_next = dec_op;
            abus_next = operand;
            dbus_next = iobr;
            io_addr   = io_index(operand);
            io_we     = 1'b1;
            io_wdata  = iobr;
          end
          OPC_WB: begin
            mbr_next = operand[7:0];
          end
          OPC_WIB: begin
            iobr_next = operand[7:0];
          end
          OPC_EOP: begin
            halt_next = ST_EOP;
          end
          default: begin
            halt_next = ST_ERR;
          end
        endcase
      end
      S_RDMEM: begin
        if (cmd == CMD_EXEC) begin
          mbr_next  = mem_rdata;
          dbus_next = mem_rdata;
        end else begin
          rd_res_next = mem_rdata;
        end
        finish = 1'b1;
      end
      S_RDIO: begin
        if (cmd == CMD_EXEC) begin
          iobr_next = io_rdata;
          dbus_next = io_rdata;
        end else begin
          rd_res_next = io_rdata;
        end
        finish = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until there is room
    if (finish) begin
      state_next = out_free ? S_IDLE : S_DONE;
    end
  end

  // Output register load: from next values on finish, from registers when held
  always_comb begin
    res_next       = res_q;
    out_valid_next = out_valid && !out_ready;
    if (finish && out_free) begin
      res_next = '{halt_next, rd_res_next, pc_next, op_res_next, mbr_next,
                   iobr_next, abus_next, dbus_next, cbus_next};
      out_valid_next = 1'b1;
    end else if (state == S_DONE && out_free) begin
      res_next = '{halt, rd_res, pc, op_res, mbr, iobr, abus, dbus, cbus};
      out_valid_next = 1'b1;
    end
  end

  // Control state and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= 11'd0;
      mbr       <= 8'd0;
      iobr      <= 8'd0;
      halt      <= ST_RUN;
      abus      <= 11'd0;
      dbus      <= 8'd0;
      cbus      <= 5'd0;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      mbr       <= mbr_next;
      iobr      <= iobr_next;
      halt      <= halt_next;
      abus      <= abus_next;
      dbus      <= dbus_next;
      cbus      <= cbus_next;
      out_valid <= out_valid_next;
      // Sweep the I/O buffer to zero after reset
      if (clearing) begin
        clr_idx <= clr_idx + IO_AW'(1);
        if (clr_idx == IO_LAST) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    ir_hi  <= ir_hi_next;
    rd_res <= rd_res_next;
    op_res <= op_res_next;
    res_q  <= res_next;
  end

  assign status          = res_q.status;
  assign read_data       = res_q.read_data;
  assign program_counter = res_q.program_counter;
  assign opcode          = res_q.opcode;
  assign memory_buffer   = res_q.memory_buffer;
  assign io_buffer_reg   = res_q.io_buffer_reg;
  assign bus_addr        = res_q.bus_addr;
  assign bus_data        = res_q.bus_data;
  assign bus_control     = res_q.bus_control;

endmodule
